[hdl/uwst_pkg.sv]
// shared types and codes for the unique word set table
package uwst_pkg;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_READ_CHAR = 3'd5,
        ST_BAD_INDEX = 3'd6,
        ST_TOO_LONG  = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_REQ,
        S_RD_DATA,
        S_CMP_ENT,
        S_CMP_RD,
        S_CMP_CHK,
        S_CP_RD,
        S_CP_WR,
        S_SH_ENT,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

endpackage

[hdl/uwst_if.sv]
// word input and result channel interfaces
interface uwst_word_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] ch;
    logic       word_end;
    logic [3:0] entry_index;

    modport source (output valid, op, ch, word_end, entry_index, input ready);
    modport sink   (input valid, op, ch, word_end, entry_index, output ready);
endinterface

interface uwst_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] word_count;
    logic [7:0] out_char;
    logic       run_end;

    modport source (output valid, status, word_count, out_char, run_end, input ready);
    modport sink   (input valid, status, word_count, out_char, run_end, output ready);
endinterface

[hdl/uwst_ram.sv]
// simple dual port synchronous ram with a registered read port
module uwst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/uwst_ctrl.sv]
// sequencer: word buffering, table search, append, compacting delete and entry read
module uwst_ctrl
    import uwst_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int MAX_LEN  = 32,
    parameter int EW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int LW       = $clog2(MAX_LEN)
) (
    input  logic               clk,
    input  logic               rst_n,
    uwst_word_if.sink          word_chan,
    uwst_result_if.source      result_chan,
    output logic               store_we,
    output logic [EW+LW-1:0]   store_waddr,
    output logic [7:0]         store_wdata,
    output logic [EW+LW-1:0]   store_raddr,
    input  logic [7:0]         store_rdata,
    output logic               pend_we,
    output logic [LW-1:0]      pend_waddr,
    output logic [7:0]         pend_wdata,
    output logic [LW-1:0]      pend_raddr,
    input  logic [7:0]         pend_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LENW = $clog2(MAX_LEN + 1);
    localparam int PLW  = $clog2(MAX_LEN + 2);

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    status_t         status_reg, status_next;
    logic [PLW-1:0]  plen_reg, plen_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ent_reg, ent_next;
    logic [LENW-1:0] pos_reg, pos_next;

    logic [LENW-1:0] len_mem [CAPACITY];
    logic            len_we;
    logic [LENW-1:0] len_wdata;

    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [4:0]      out_count_reg, out_count_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_end_reg, out_end_next;
    logic            out_load;

    logic            slot_free;
    logic            in_shift;
    logic [CW-1:0]   ent_inc;
    logic [CW-1:0]   len_idx;
    logic [LENW-1:0] len_rd;
    logic [LENW-1:0] pos_inc;
    logic            pos_last_len;
    logic            pos_last_p;
    logic            too_long;
    logic [7:0]      idx8;
    logic [7:0]      cnt8;

    assign slot_free    = !out_valid_reg || result_chan.ready;
    assign in_shift     = (state_reg == S_SH_ENT) || (state_reg == S_SH_RD) ||
                          (state_reg == S_SH_WR);
    assign ent_inc      = ent_reg + 1'b1;
    assign len_idx      = in_shift ? ent_inc : ent_reg;
    assign len_rd       = len_mem[len_idx[EW-1:0]];
    assign pos_inc      = pos_reg + 1'b1;
    assign pos_last_len = (pos_inc == len_rd);
    assign pos_last_p   = (PLW'(pos_inc) == plen_reg);
    assign too_long     = (plen_reg >= PLW'(MAX_LEN));
    assign idx8         = 8'(word_chan.entry_index);
    assign cnt8         = 8'(count_reg);

    assign result_chan.valid      = out_valid_reg;
    assign result_chan.status     = out_status_reg;
    assign result_chan.word_count = out_count_reg;
    assign result_chan.out_char   = out_char_reg;
    assign result_chan.run_end    = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plen_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        ent_reg        <= ent_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_char_reg   <= out_char_next;
        out_end_reg    <= out_end_next;
        if (len_we)
        begin
            len_mem[ent_reg[EW-1:0]] <= len_wdata;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        plen_next       = plen_reg;
        count_next      = count_reg;
        ent_next        = ent_reg;
        pos_next        = pos_reg;
        word_chan.ready = 1'b0;
        store_we        = 1'b0;
        store_waddr     = {ent_reg[EW-1:0], pos_reg[LW-1:0]};
        store_wdata     = (state_reg == S_SH_WR) ? store_rdata : pend_rdata;
        store_raddr     = in_shift ? {ent_inc[EW-1:0], pos_reg[LW-1:0]}
                                   : {ent_reg[EW-1:0], pos_reg[LW-1:0]};
        pend_we         = 1'b0;
        pend_waddr      = plen_reg[LW-1:0];
        pend_wdata      = word_chan.ch;
        pend_raddr      = pos_reg[LW-1:0];
        len_we          = 1'b0;
        len_wdata       = len_rd;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_char_next   = out_char_reg;
        out_end_next    = out_end_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                word_chan.ready = 1'b1;
                if (word_chan.valid)
                begin
                    case (op_t'(word_chan.op))
                        OP_READ:
                        begin
                            op_next = OP_READ;
                            if (idx8 >= cnt8)
                            begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ent_next   = CW'(idx8);
                                pos_next   = '0;
                                state_next = S_RD_REQ;
                            end
                        end
                        OP_ADD, OP_DEL:
                        begin
                            op_next = op_t'(word_chan.op);
                            if (too_long)
                            begin
                                plen_next = PLW'(MAX_LEN + 1);
                            end
                            else
                            begin
                                pend_we   = 1'b1;
                                plen_next = plen_reg + 1'b1;
                            end
                            if (word_chan.word_end)
                            begin
                                if (too_long)
                                begin
                                    status_next = ST_TOO_LONG;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    ent_next   = '0;
                                    state_next = S_CMP_ENT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_REQ:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_READ_CHAR;
                    out_count_next  = 5'(count_reg);
                    out_char_next   = store_rdata;
                    out_end_next    = pos_last_len;
                    if (pos_last_len)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = S_RD_REQ;
                    end
                end
            end
            S_CMP_ENT:
            begin
                if (ent_reg >= count_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ent_next   = count_reg;
                            pos_next   = '0;
                            state_next = S_CP_RD;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else if (PLW'(len_rd) != plen_reg)
                begin
                    ent_next = ent_inc;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (store_rdata != pend_rdata)
                begin
                    ent_next   = ent_inc;
                    state_next = S_CMP_ENT;
                end
                else if (pos_last_p)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_ENT;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_CMP_RD;
                end
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                store_we = 1'b1;
                if (pos_last_p)
                begin
                    len_we      = 1'b1;
                    len_wdata   = LENW'(plen_reg);
                    count_next  = count_reg + 1'b1;
                    status_next = ST_ADDED;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_CP_RD;
                end
            end
            S_SH_ENT:
            begin
                if (ent_inc >= count_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_DELETED;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                // move one char of the next entry down a row
                store_we = 1'b1;
                if (pos_last_len)
                begin
                    len_we     = 1'b1;
                    ent_next   = ent_inc;
                    state_next = S_SH_ENT;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_SH_RD;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = 5'(count_reg);
                    out_char_next   = '0;
                    out_end_next    = 1'b1;
                    // a read keeps the pending word
                    if (op_reg != OP_READ)
                    begin
                        plen_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (result_chan.ready ? 1'b0 : out_valid_reg);
    end

endmodule

[hdl/unique_word_set_table_core.sv]
// unique word set table: top level
// a non-final char item is buffered in the pending ram; a word end starts a search
// of the table, then an append or, for a delete, a shift of each later entry
// a read alternates request and data states on the single word ram read port
// every result leaves through one output register; items are taken only when idle
// rst_n clears the word count, pending length and output valid; rams are not cleared
module unique_word_set_table_core
    import uwst_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int MAX_LEN  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    uwst_word_if.sink     word_chan,
    uwst_result_if.source result_chan
);

    localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(MAX_LEN);

    logic             store_we;
    logic [EW+LW-1:0] store_waddr;
    logic [7:0]       store_wdata;
    logic [EW+LW-1:0] store_raddr;
    logic [7:0]       store_rdata;
    logic             pend_we;
    logic [LW-1:0]    pend_waddr;
    logic [7:0]       pend_wdata;
    logic [LW-1:0]    pend_raddr;
    logic [7:0]       pend_rdata;

    uwst_ctrl #(
        .CAPACITY (CAPACITY),
        .MAX_LEN  (MAX_LEN),
        .EW       (EW),
        .LW       (LW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_chan   (word_chan),
        .result_chan (result_chan),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .pend_we     (pend_we),
        .pend_waddr  (pend_waddr),
        .pend_wdata  (pend_wdata),
        .pend_raddr  (pend_raddr),
        .pend_rdata  (pend_rdata)
    );

    // one row of 2**LW chars per entry
    uwst_ram #(
        .DEPTH (CAPACITY * (2 ** LW)),
        .WIDTH (8)
    ) u_word_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    uwst_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (8)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

endmodule

[hdl/uwst_checker.sv]
// port-level checks for the unique word set table
module uwst_checker
    import uwst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] out_char,
    input logic       run_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_READ_CHAR |-> out_char == 8'd0)
        else $error("nonzero char on a status result");

    a_single_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_READ_CHAR |-> run_end)
        else $error("status result not marked as run end");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_READ_CHAR && !run_end |-> !in_ready)
        else $error("item taken in the middle of a read run");

endmodule

bind unique_word_set_table_core uwst_checker u_uwst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (word_chan.ready),
    .out_valid (result_chan.valid),
    .out_ready (result_chan.ready),
    .status    (result_chan.status),
    .out_char  (result_chan.out_char),
    .run_end   (result_chan.run_end)
);

[tb/sv/unique_word_set_table_core_test.sv]
// testbench for the unique word set table: directed and random words checked against a model
`timescale 1ns / 1ps
module unique_word_set_table_core_test;
    import uwst_pkg::*;

    localparam int CAPACITY = 16;
    localparam int MAX_LEN  = 32;

    typedef struct packed {
        op_t      op;
        logic [7:0] ch;
        logic     word_end;
        logic [3:0] entry_index;
    } word_item_t;

    typedef struct packed {
        status_t  status;
        logic [4:0] word_count;
        logic [7:0] out_char;
        logic     run_end;
    } result_item_t;

    logic clk;
    logic rst_n;

    uwst_word_if   word_chan ();
    uwst_result_if result_chan ();

    unique_word_set_table_core #(.CAPACITY(CAPACITY), .MAX_LEN(MAX_LEN)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_chan   (word_chan.sink),
        .result_chan (result_chan.source)
    );

    // table model
    logic [7:0] tbl_chars [CAPACITY][MAX_LEN];
    int         tbl_len [CAPACITY];
    int         tbl_count;
    logic [7:0] word_buf [MAX_LEN];
    int         word_len;

    word_item_t   pending_items [$];
    result_item_t expected_results [$];
    int           mismatches;
    int           sync_req;
    int           hold_off_cycles;
    logic         in_accepted;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic result_item_t make_result(status_t st, logic [7:0] c, logic last);
        result_item_t r;
        r.status = st;
        r.word_count = tbl_count[4:0];
        r.out_char = c;
        r.run_end = last;
        return r;
    endfunction

    function automatic int find_stored_word();
        int i;
        int j;
        bit same;
        for (i = 0; i < tbl_count; i++)
        begin
            if (tbl_len[i] == word_len)
            begin
                same = 1'b1;
                for (j = 0; j < word_len; j++)
                    if (tbl_chars[i][j] != word_buf[j])
                        same = 1'b0;
                if (same)
                    return i;
            end
        end
        return -1;
    endfunction

    task automatic predict_table(input word_item_t it);
        int hit;
        int i;
        status_t st;
        if (it.op == OP_READ)
        begin
            if (it.entry_index >= tbl_count)
                expected_results.push_back(make_result(ST_BAD_INDEX, 8'd0, 1'b1));
            else
                for (i = 0; i < tbl_len[it.entry_index]; i++)
                    expected_results.push_back(make_result(ST_READ_CHAR,
                        tbl_chars[it.entry_index][i], i + 1 == tbl_len[it.entry_index]));
            return;
        end
        if (it.op == OP_NONE)
            return;
        if (word_len >= MAX_LEN)
            word_len = MAX_LEN + 1;
        else
        begin
            word_buf[word_len] = it.ch;
            word_len++;
        end
        if (!it.word_end)
            return;
        if (word_len > MAX_LEN)
            st = ST_TOO_LONG;
        else
        begin
            hit = find_stored_word();
            if (it.op == OP_ADD)
            begin
                if (hit >= 0)
                    st = ST_DUPLICATE;
                else if (tbl_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (i = 0; i < word_len; i++)
                        tbl_chars[tbl_count][i] = word_buf[i];
                    tbl_len[tbl_count] = word_len;
                    tbl_count++;
                    st = ST_ADDED;
                end
            end
            else if (hit < 0)
                st = ST_NOT_FOUND;
            else
            begin
                for (i = hit; i + 1 < tbl_count; i++)
                begin
                    tbl_chars[i] = tbl_chars[i + 1];
                    tbl_len[i] = tbl_len[i + 1];
                end
                tbl_count--;
                st = ST_DELETED;
            end
        end
        word_len = 0;
        expected_results.push_back(make_result(st, 8'd0, 1'b1));
    endtask

    // stimulus builders
    task automatic queue_word(input op_t op, input logic [7:0] w [$]);
        word_item_t it;
        int i;
        for (i = 0; i < w.size(); i++)
        begin
            it.op = op;
            it.ch = w[i];
            it.word_end = (i == w.size() - 1);
            it.entry_index = 4'($urandom);
            pending_items.push_back(it);
        end
    endtask

    task automatic queue_read(input logic [3:0] idx);
        word_item_t it;
        it.op = OP_READ;
        it.ch = 8'($urandom);
        it.word_end = 1'($urandom);
        it.entry_index = idx;
        pending_items.push_back(it);
    endtask

    // short words over a small alphabet so duplicates and deletes hit often
    function automatic void pick_word(output logic [7:0] w [$], input int len);
        int i;
        w = {};
        for (i = 0; i < len; i++)
            w.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 99)));
    endfunction

    // driver
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_chan.valid <= 1'b0;
            word_chan.op <= OP_ADD;
            word_chan.ch <= 8'd0;
            word_chan.word_end <= 1'b0;
            word_chan.entry_index <= 4'd0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!word_chan.valid || in_accepted)
        begin
            if (gap_left > 0 || sync_req != 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                word_chan.valid <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                word_chan.valid <= 1'b1;
                {word_chan.op, word_chan.ch, word_chan.word_end, word_chan.entry_index}
                    <= pending_items[0];
            end
        end
    end

    // accept at rising edge, advance the queue and the model
    always @(posedge clk)
    begin
        in_accepted = 1'b0;
        if (rst_n && word_chan.valid && word_chan.ready)
        begin
            in_accepted = 1'b1;
            predict_table(pending_items.pop_front());
        end
    end

    // receiver stall pattern and long hold-off
    int stall_phase;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_chan.ready <= 1'b0;
            stall_phase = 0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            result_chan.ready <= 1'b0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 24)
                result_chan.ready <= 1'b1;
            else
                result_chan.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_item_t got;
        result_item_t exp_r;
        if (rst_n && result_chan.valid && result_chan.ready)
        begin
            got.status = status_t'(result_chan.status);
            got.word_count = result_chan.word_count;
            got.out_char = result_chan.out_char;
            got.run_end = result_chan.run_end;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d count %0d char %0h end %0b",
                        got.status, got.word_count, got.out_char, got.run_end);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp status %0d count %0d char %0h end %0b,",
                                  " got status %0d count %0d char %0h end %0b"},
                            exp_r.status, exp_r.word_count, exp_r.out_char, exp_r.run_end,
                            got.status, got.word_count, got.out_char, got.run_end);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || word_chan.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [7:0] w [$];
        logic [7:0] long_w [$];
        int i;
        int n;
        int pick;
        int wl;
        tbl_count = 0;
        word_len = 0;
        mismatches = 0;
        sync_req = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty read, extremes, duplicate, full, delete, too long, mixed ops
        queue_read(4'd0);
        queue_word(OP_ADD, {8'h00});
        queue_word(OP_ADD, {8'hff, 8'h01});
        queue_word(OP_ADD, {8'h00});
        long_w = {};
        for (i = 0; i < MAX_LEN; i++)
            long_w.push_back(8'(i * 37 + 5));
        queue_word(OP_ADD, long_w);
        queue_read(4'd2);
        long_w.push_back(8'haa);
        queue_word(OP_DEL, long_w);
        queue_word(OP_DEL, {8'h00});
        queue_word(OP_DEL, {8'h55});
        begin
            word_item_t it;
            it = '{op: OP_NONE, ch: 8'h12, word_end: 1'b1, entry_index: 4'hf};
            pending_items.push_back(it);
        end
        queue_word(OP_DEL, {8'hff});
        pending_items[pending_items.size() - 1].word_end = 1'b0;
        queue_read(4'd0);
        queue_word(OP_ADD, {8'h01});
        queue_read(4'hf);
        wait_drained();
        // fill to capacity with distinct words, then full and duplicate-when-full
        for (i = tbl_count; i < CAPACITY; i++)
            queue_word(OP_ADD, {8'h80, 8'(i)});
        queue_word(OP_ADD, {8'h7e});
        queue_word(OP_ADD, {8'h80, 8'd3});
        queue_read(4'hf);
        // long receiver hold-off while items keep coming
        hold_off_cycles = 3000;
        wait_drained();
        for (i = 0; i < CAPACITY; i++)
            queue_word(OP_DEL, {8'h80, 8'(i)});
        wait_drained();
        for (i = 0; i < CAPACITY; i++)
            queue_word(OP_DEL, {8'h80, 8'(i)});
        queue_word(OP_DEL, long_w);
        queue_word(OP_DEL, {8'hff, 8'h01});
        queue_word(OP_DEL, {8'h01});

        // random part
        n = 0;
        while (n < 60)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                pick_word(w, $urandom_range(1, 4));
                queue_word(OP_ADD, w);
                n += w.size();
            end
            else if (pick < 65)
            begin
                pick_word(w, $urandom_range(1, 4));
                queue_word(OP_DEL, w);
                n += w.size();
            end
            else if (pick < 85)
            begin
                queue_read(4'($urandom));
                n++;
            end
            else if (pick < 90)
            begin
                w = {};
                wl = $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
                for (i = 0; i < wl; i++)
                    w.push_back(8'($urandom));
                queue_word(($urandom_range(0, 1) != 0) ? OP_ADD : OP_DEL, w);
                n += w.size();
            end
            else if (pick < 94)
            begin
                pick_word(w, $urandom_range(2, 4));
                queue_word(OP_ADD, w);
                pending_items[pending_items.size() - 1].op = OP_DEL;
                pending_items[pending_items.size() - 2].op = op_t'($urandom_range(0, 1));
                n += w.size();
            end
            else
            begin
                word_item_t it;
                it = '{op: OP_NONE, ch: 8'($urandom), word_end: 1'($urandom),
                       entry_index: 4'($urandom)};
                pending_items.push_back(it);
                n++;
            end
            if (n > 20 && n < 30 && sync_req == 0)
            begin
                // wait until the block has caught up, then hold the sender idle before going on
                wait_drained();
                sync_req = 1;
                repeat (20) @(posedge clk);
                sync_req = 0;
            end
        end
        wait_drained();
        repeat (2 * CAPACITY * (2 * MAX_LEN + 1) + 200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/uwst_pkg.sv
hdl/uwst_if.sv
hdl/uwst_ram.sv
hdl/uwst_ctrl.sv
hdl/unique_word_set_table_core.sv
hdl/uwst_checker.sv
tb/sv/unique_word_set_table_core_test.sv
